// ===== sv/pxa_pkg.sv =====
`default_nettype none

package pxa_pkg;

	// Rec.601 luma weights in Q16; they sum to 65536.
	localparam logic [15:0] W_RED   = 16'd19595;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_BLUE  = 16'd7471;

	// Configuration register indexes.
	localparam logic [3:0] CFG_EDGE_MODE       = 4'd0;
	localparam logic [3:0] CFG_COLOR_ENABLE    = 4'd1;
	localparam logic [3:0] CFG_INVERT_RAMP     = 4'd2;
	localparam logic [3:0] CFG_BOOST_GAIN      = 4'd3;
	localparam logic [3:0] CFG_RAMP_LENGTH     = 4'd4;
	localparam logic [3:0] CFG_RAMP_CHARS_LOW  = 4'd5;
	localparam logic [3:0] CFG_RAMP_CHARS_HIGH = 4'd6;
	localparam logic [3:0] CFG_IMAGE_WIDTH     = 4'd7;

	// Register file contents as seen by the front end.
	typedef struct packed {
		logic         edge_mode;
		logic         color_enable;
		logic         invert_ramp;
		logic [11:0]  boost_gain;
		logic [4:0]   ramp_length;
		logic [127:0] ramp_chars;
		logic [12:0]  image_width;
	} pxa_cfg_t;

	// Decimal form of one color byte: digit count and three digits.
	typedef struct packed {
		logic [1:0] nd;
		logic [3:0] d2;
		logic [3:0] d1;
		logic [3:0] d0;
	} pxa_dec_t;

	// One classified pixel, handed from the front end to the byte sequencer.
	typedef struct packed {
		logic       frame_start;
		logic       color;
		logic       row_end;
		logic [7:0] glyph;
		pxa_dec_t   red;
		pxa_dec_t   green;
		pxa_dec_t   blue;
	} pxa_item_t;

	// Splits a byte into decimal digits. Tens use a reciprocal multiply,
	// which is exact for values below 100.
	function automatic pxa_dec_t dec_digits(input logic [7:0] v);
		pxa_dec_t    d;
		logic [6:0]  rem;
		logic [14:0] prod;
		logic [3:0]  tens;
		if (v >= 8'd200) begin
			d.d2 = 4'd2;
			rem  = 7'(v - 8'd200);
		end else if (v >= 8'd100) begin
			d.d2 = 4'd1;
			rem  = 7'(v - 8'd100);
		end else begin
			d.d2 = 4'd0;
			rem  = v[6:0];
		end
		prod = 15'(rem) * 15'd205;
		tens = prod[14:11];
		d.d1 = tens;
		d.d0 = 4'(rem - 7'({tens, 3'b000}) - 7'({tens, 1'b0}));
		if (v >= 8'd100) begin
			d.nd = 2'd3;
		end else if (v >= 8'd10) begin
			d.nd = 2'd2;
		end else begin
			d.nd = 2'd1;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== sv/pxa_front.sv =====
`default_nettype none

module pxa_front import pxa_pkg::*; #(
	parameter int RAMP_MAX    = 16,
	parameter int MAX_COLUMNS = 4096
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire pxa_cfg_t   cfg,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] pixel_red,
	input  wire logic [7:0] pixel_green,
	input  wire logic [7:0] pixel_blue,
	input  wire logic [15:0] edge_strength,
	input  wire logic       first_of_frame,
	output logic            q_push,
	output pxa_item_t       q_item,
	input  wire logic       q_full
);

	localparam int WW = ($clog2(MAX_COLUMNS + 1) > 13) ? $clog2(MAX_COLUMNS + 1) : 13;
	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam logic [4:0]    RAMP_N  = 5'(RAMP_MAX);
	localparam logic [WW-1:0] COL_MAX = WW'(MAX_COLUMNS);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LUMA  = 5'b00010,
		ST_SCALE = 5'b00100,
		ST_INDEX = 5'b01000,
		ST_PUSH  = 5'b10000
	} fe_state_t;

	fe_state_t      state_q;
	logic [1:0]     step_q;
	logic [7:0]     red_q, green_q, blue_q;
	logic [15:0]    edge_q;
	logic           frame_start_q;
	logic [23:0]    acc_q;
	logic [27:0]    prod_q;
	logic [4:0]     raw_idx_q;
	logic [CW-1:0]  col_q;

	logic [4:0]     n_ramp, nm1, capped, idx;
	logic [WW-1:0]  width_eff, col_inc;
	logic [CW-1:0]  col_base;
	logic [15:0]    weight;
	logic [7:0]     chan;
	logic [23:0]    lum_term;
	logic [15:0]    src, shifted;
	logic [7:0]     value;
	logic [12:0]    idx_prod;
	logic           row_end;
	logic           accept;

	assign full   = (state_q != ST_IDLE);
	assign accept = push && !full;
	assign q_push = (state_q == ST_PUSH) && !q_full;

	// Clamp the ramp length and row width to their legal ranges.
	always_comb begin
		if (cfg.ramp_length == 5'd0) begin
			n_ramp = 5'd1;
		end else if (cfg.ramp_length > RAMP_N) begin
			n_ramp = RAMP_N;
		end else begin
			n_ramp = cfg.ramp_length;
		end
		width_eff = WW'(cfg.image_width);
		if (width_eff == '0) begin
			width_eff = WW'(1);
		end else if (width_eff > COL_MAX) begin
			width_eff = COL_MAX;
		end
	end

	// One weighted channel is added into the luma sum per cycle.
	always_comb begin
		case (step_q)
			2'd0: begin
				weight = W_RED;
				chan   = red_q;
			end
			2'd1: begin
				weight = W_GREEN;
				chan   = green_q;
			end
			default: begin
				weight = W_BLUE;
				chan   = blue_q;
			end
		endcase
		lum_term = 24'(weight) * 24'(chan);
	end

	// Gain, saturation and ramp index arithmetic.
	always_comb begin
		src      = cfg.edge_mode ? edge_q : {8'd0, acc_q[23:16]};
		shifted  = cfg.edge_mode ? prod_q[27:12] : {4'd0, prod_q[19:8]};
		value    = (|shifted[15:8]) ? 8'hFF : shifted[7:0];
		idx_prod = 13'(value) * 13'(n_ramp);
		nm1      = n_ramp - 5'd1;
		capped   = (raw_idx_q > nm1) ? nm1 : raw_idx_q;
		idx      = cfg.invert_ramp ? (nm1 - capped) : capped;
	end

	// Column tracking; a frame start restarts the row.
	always_comb begin
		col_base = frame_start_q ? '0 : col_q;
		col_inc  = WW'(col_base) + WW'(1);
		row_end  = (col_inc >= width_eff);
	end

	// Classified item for the queue.
	always_comb begin
		q_item.frame_start = frame_start_q;
		q_item.color       = cfg.color_enable;
		q_item.row_end     = row_end;
		q_item.glyph       = cfg.ramp_chars[{idx[3:0], 3'b000} +: 8];
		q_item.red         = dec_digits(red_q);
		q_item.green       = dec_digits(green_q);
		q_item.blue        = dec_digits(blue_q);
	end

	// Sequencer for one pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= 2'd0;
			col_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LUMA;
						step_q  <= 2'd0;
					end
				end
				ST_LUMA: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd2) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_INDEX;
				ST_INDEX: state_q <= ST_PUSH;
				ST_PUSH: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
						col_q   <= row_end ? '0 : CW'(col_inc);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			red_q         <= pixel_red;
			green_q       <= pixel_green;
			blue_q        <= pixel_blue;
			edge_q        <= edge_strength;
			frame_start_q <= first_of_frame;
			acc_q         <= '0;
		end
		if (state_q == ST_LUMA) begin
			acc_q <= acc_q + lum_term;
		end
		if (state_q == ST_SCALE) begin
			prod_q <= 28'(src) * 28'(cfg.boost_gain);
		end
		if (state_q == ST_INDEX) begin
			raw_idx_q <= idx_prod[12:8];
		end
	end

endmodule

`default_nettype wire

// ===== sv/pxa_queue.sv =====
`default_nettype none

module pxa_queue import pxa_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire pxa_item_t push_item,
	output logic           full,
	input  wire logic      pop,
	output pxa_item_t      pop_item,
	output logic           empty
);

	pxa_item_t  mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== sv/pxa_back.sv =====
`default_nettype none

module pxa_back import pxa_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pxa_item_t q_item,
	input  wire logic      q_empty,
	output logic           q_pop,
	output logic           empty,
	input  wire logic      pop,
	output logic [7:0]     text_byte,
	output logic           last_byte
);

	localparam int SLOTS = 26;

	// Fixed byte positions of the longest sequence.
	localparam logic [4:0] SL_NL_FIRST = 5'd0;
	localparam logic [4:0] SL_ESC1     = 5'd1;
	localparam logic [4:0] SL_LB1      = 5'd2;
	localparam logic [4:0] SL_C3       = 5'd3;
	localparam logic [4:0] SL_C8       = 5'd4;
	localparam logic [4:0] SL_SC1      = 5'd5;
	localparam logic [4:0] SL_C2       = 5'd6;
	localparam logic [4:0] SL_SC2      = 5'd7;
	localparam logic [4:0] SL_R2       = 5'd8;
	localparam logic [4:0] SL_R1       = 5'd9;
	localparam logic [4:0] SL_R0       = 5'd10;
	localparam logic [4:0] SL_SC3      = 5'd11;
	localparam logic [4:0] SL_G2       = 5'd12;
	localparam logic [4:0] SL_G1       = 5'd13;
	localparam logic [4:0] SL_G0       = 5'd14;
	localparam logic [4:0] SL_SC4      = 5'd15;
	localparam logic [4:0] SL_B2       = 5'd16;
	localparam logic [4:0] SL_B1       = 5'd17;
	localparam logic [4:0] SL_B0       = 5'd18;
	localparam logic [4:0] SL_M1       = 5'd19;
	localparam logic [4:0] SL_CHAR     = 5'd20;
	localparam logic [4:0] SL_ESC2     = 5'd21;
	localparam logic [4:0] SL_LB2      = 5'd22;
	localparam logic [4:0] SL_C0       = 5'd23;
	localparam logic [4:0] SL_M2       = 5'd24;
	localparam logic [4:0] SL_NL_ROW   = 5'd25;

	localparam logic [7:0] ASC_NL   = 8'h0A;
	localparam logic [7:0] ASC_ESC  = 8'h1B;
	localparam logic [7:0] ASC_LB   = 8'h5B;
	localparam logic [7:0] ASC_0    = 8'h30;
	localparam logic [7:0] ASC_2    = 8'h32;
	localparam logic [7:0] ASC_3    = 8'h33;
	localparam logic [7:0] ASC_8    = 8'h38;
	localparam logic [7:0] ASC_SEMI = 8'h3B;
	localparam logic [7:0] ASC_M    = 8'h6D;

	logic [SLOTS-1:0] pend_q, mask;
	pxa_item_t        cur_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [4:0]       slot;
	logic [7:0]       slot_byte;
	logic             out_free, emit, load, is_last;

	assign empty     = !out_valid_q;
	assign text_byte = byte_q;
	assign last_byte = last_q;
	assign out_free  = !out_valid_q || pop;
	assign emit      = (pend_q != '0) && out_free;
	assign load      = (pend_q == '0) && !q_empty;
	assign q_pop     = load;
	assign is_last   = ((pend_q & (pend_q - SLOTS'(1))) == '0);

	// Which byte positions the incoming item needs.
	always_comb begin
		logic c;
		c = q_item.color;
		mask              = '0;
		mask[SL_NL_FIRST] = q_item.frame_start;
		mask[SL_ESC1]     = c;
		mask[SL_LB1]      = c;
		mask[SL_C3]       = c;
		mask[SL_C8]       = c;
		mask[SL_SC1]      = c;
		mask[SL_C2]       = c;
		mask[SL_SC2]      = c;
		mask[SL_R2]       = c && (q_item.red.nd == 2'd3);
		mask[SL_R1]       = c && (q_item.red.nd >= 2'd2);
		mask[SL_R0]       = c;
		mask[SL_SC3]      = c;
		mask[SL_G2]       = c && (q_item.green.nd == 2'd3);
		mask[SL_G1]       = c && (q_item.green.nd >= 2'd2);
		mask[SL_G0]       = c;
		mask[SL_SC4]      = c;
		mask[SL_B2]       = c && (q_item.blue.nd == 2'd3);
		mask[SL_B1]       = c && (q_item.blue.nd >= 2'd2);
		mask[SL_B0]       = c;
		mask[SL_M1]       = c;
		mask[SL_CHAR]     = 1'b1;
		mask[SL_ESC2]     = c && q_item.row_end;
		mask[SL_LB2]      = c && q_item.row_end;
		mask[SL_C0]       = c && q_item.row_end;
		mask[SL_M2]       = c && q_item.row_end;
		mask[SL_NL_ROW]   = q_item.row_end;
	end

	// Lowest pending position is the next byte to send.
	always_comb begin
		slot = 5'd0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				slot = 5'(i);
			end
		end
	end

	// Byte value at a position.
	always_comb begin
		unique case (slot)
			SL_NL_FIRST, SL_NL_ROW:          slot_byte = ASC_NL;
			SL_ESC1, SL_ESC2:                slot_byte = ASC_ESC;
			SL_LB1, SL_LB2:                  slot_byte = ASC_LB;
			SL_C3:                           slot_byte = ASC_3;
			SL_C8:                           slot_byte = ASC_8;
			SL_C2:                           slot_byte = ASC_2;
			SL_C0:                           slot_byte = ASC_0;
			SL_SC1, SL_SC2, SL_SC3, SL_SC4:  slot_byte = ASC_SEMI;
			SL_M1, SL_M2:                    slot_byte = ASC_M;
			SL_R2:   slot_byte = ASC_0 + {4'd0, cur_q.red.d2};
			SL_R1:   slot_byte = ASC_0 + {4'd0, cur_q.red.d1};
			SL_R0:   slot_byte = ASC_0 + {4'd0, cur_q.red.d0};
			SL_G2:   slot_byte = ASC_0 + {4'd0, cur_q.green.d2};
			SL_G1:   slot_byte = ASC_0 + {4'd0, cur_q.green.d1};
			SL_G0:   slot_byte = ASC_0 + {4'd0, cur_q.green.d0};
			SL_B2:   slot_byte = ASC_0 + {4'd0, cur_q.blue.d2};
			SL_B1:   slot_byte = ASC_0 + {4'd0, cur_q.blue.d1};
			SL_B0:   slot_byte = ASC_0 + {4'd0, cur_q.blue.d0};
			SL_CHAR: slot_byte = cur_q.glyph;
			default: slot_byte = cur_q.glyph;
		endcase
	end

	// Pending positions and output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= mask;
			end else if (emit) begin
				pend_q <= pend_q & (pend_q - SLOTS'(1));
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_item;
		end
		if (emit) begin
			byte_q <= slot_byte;
			last_q <= is_last;
		end
	end

endmodule

`default_nettype wire

// ===== sv/pixel_to_ascii_terminal_encoder_unit.sv =====
// Pixel to terminal text encoder.
// Pixels enter through a queue-style port: an item transfers on a clock edge
// with push high and full low. Text bytes leave through a queue-style port:
// the oldest byte is on text_byte/last_byte while empty is low and transfers
// on an edge with pop high. last_byte marks the final byte of each pixel.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high and unknown indexes are dropped. Write them only
// while no pixel is in flight.
// The front end works on one pixel at a time (three luma accumulate steps,
// gain multiply, index multiply, queue write) and accepts the next pixel only
// after the queue write. A two-entry queue decouples it from the byte
// sequencer, which loads an entry once it has no bytes pending and then
// sends one byte per cycle while the output register is free: 1 byte for a
// plain pixel up to 26 for a color pixel at frame start and row end.
// When the receiver stops popping, the output register holds, the sequencer
// and queue fill, and full rises. Reset empties everything, clears the
// column counter and loads register defaults.

`default_nettype none

module pixel_to_ascii_terminal_encoder_unit import pxa_pkg::*; #(
	parameter int RAMP_MAX    = 16,
	parameter int MAX_COLUMNS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  pixel_red,
	input  wire logic [7:0]  pixel_green,
	input  wire logic [7:0]  pixel_blue,
	input  wire logic [15:0] edge_strength,
	input  wire logic        first_of_frame,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       text_byte,
	output logic             last_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	pxa_cfg_t  cfg_q;
	pxa_item_t f_item, b_item;
	logic      f_push, q_full, q_empty, b_pop;

	assign cfg_ready = 1'b1;

	// Register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_mode    <= 1'b0;
			cfg_q.color_enable <= 1'b0;
			cfg_q.invert_ramp  <= 1'b0;
			cfg_q.boost_gain   <= 12'd256;
			cfg_q.ramp_length  <= 5'd10;
			cfg_q.ramp_chars   <= '0;
			cfg_q.image_width  <= 13'd80;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_EDGE_MODE:       cfg_q.edge_mode          <= cfg_data[0];
				CFG_COLOR_ENABLE:    cfg_q.color_enable       <= cfg_data[0];
				CFG_INVERT_RAMP:     cfg_q.invert_ramp        <= cfg_data[0];
				CFG_BOOST_GAIN:      cfg_q.boost_gain         <= cfg_data[11:0];
				CFG_RAMP_LENGTH:     cfg_q.ramp_length        <= cfg_data[4:0];
				CFG_RAMP_CHARS_LOW:  cfg_q.ramp_chars[63:0]   <= cfg_data;
				CFG_RAMP_CHARS_HIGH: cfg_q.ramp_chars[127:64] <= cfg_data;
				CFG_IMAGE_WIDTH:     cfg_q.image_width        <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	pxa_front #(
		.RAMP_MAX    (RAMP_MAX),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.push           (push),
		.full           (full),
		.pixel_red      (pixel_red),
		.pixel_green    (pixel_green),
		.pixel_blue     (pixel_blue),
		.edge_strength  (edge_strength),
		.first_of_frame (first_of_frame),
		.q_push         (f_push),
		.q_item         (f_item),
		.q_full         (q_full)
	);

	pxa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_item (f_item),
		.full      (q_full),
		.pop       (b_pop),
		.pop_item  (b_item),
		.empty     (q_empty)
	);

	pxa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (b_item),
		.q_empty   (q_empty),
		.q_pop     (b_pop),
		.empty     (empty),
		.pop       (pop),
		.text_byte (text_byte),
		.last_byte (last_byte)
	);

endmodule

`default_nettype wire
